>>> rtl/core/vsu_pkg.sv
// shared constants and types of the viscoplastic stress update
package vsu_pkg;

	localparam int SUBSTEPS = 100;
	localparam int MAX_ITER = 1000;

	localparam int SUB_W  = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
	localparam int ITER_W = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;

	// sub-step length by reciprocal multiply, the estimate is at most one low
	localparam int          RECIP_SH  = 31 + $clog2(SUBSTEPS);
	localparam logic [31:0] SUB_RECIP = 32'((64'd1 << RECIP_SH) / SUBSTEPS);

	localparam int E_W   = 20;
	localparam int S0_W  = 31;
	localparam int ETA_W = 32;
	localparam int T_W   = 32;
	localparam int TOL_W = 30;

	localparam logic [34:0] INC_CAP = 35'h4_0000_0000;

	typedef enum logic [2:0] {
		REG_YOUNGS    = 3'd0,
		REG_YIELD     = 3'd1,
		REG_VISCOSITY = 3'd2,
		REG_TIME_STEP = 3'd3,
		REG_TOLERANCE = 3'd4
	} reg_index_t;

	localparam logic [E_W-1:0]   YOUNGS_RST    = 20'd100000;
	localparam logic [S0_W-1:0]  YIELD_RST     = 31'd25600;
	localparam logic [ETA_W-1:0] VISCOSITY_RST = 32'd65536;
	localparam logic [T_W-1:0]   TIME_STEP_RST = 32'd16777216;
	localparam logic [TOL_W-1:0] TOLERANCE_RST = 30'd10737;

endpackage

>>> rtl/core/viscoplastic_stress_update.sv
// top level: one-dimensional perzyna viscoplastic stress update, iterative datapath
//
// An item is taken when start is high and busy is low; busy then stays high until the
// result is ready, and the result is shown for one cycle with done high, in the cycle after
// busy drops, so a new start may already be taken then. The receiver cannot stall. All
// work runs on one 32x32 multiplier and one radix-2 restoring divider (one quotient bit a
// cycle) under a sequencer. Each item runs a setup (the sub-step length comes from a
// reciprocal multiply and one correction step), then each of the 100 sub-steps runs
// 1 + n evaluations (guess plus n fixed-point iterations, n at most 1000), each with a
// 61-bit overstress division when yielding, and at the end a tangent division when the
// final stress is not elastic.
module viscoplastic_stress_update import vsu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic signed [31:0]  old_plastic_strain,
	input  logic signed [31:0]  total_strain,
	output logic signed [31:0]  stress,
	output logic signed [31:0]  new_plastic_strain,
	output logic [27:0]         tangent_modulus
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_HMUL, ST_HFIX, ST_HCOR, ST_KMUL, ST_KSET, ST_SMUL, ST_STRESS, ST_RDIV,
		ST_PP, ST_CAP, ST_APPLY, ST_TMUL0, ST_TMUL1, ST_TMUL2, ST_TMUL3, ST_TMUL4, ST_TDIV
	} state_t;

	typedef enum logic [1:0] {PH_GUESS, PH_ITER, PH_FINAL, PH_DONE} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic [SUB_W-1:0]  sub_cnt_q;
	logic [ITER_W-1:0] iter_cnt_q;
	logic [6:0]        div_cnt_q;
	logic [2:0]        pp_idx_q;
	logic              done_q;
	logic              out_q;

	logic [E_W-1:0]   youngs_q;
	logic [S0_W-1:0]  yield_q;
	logic [ETA_W-1:0] eta_q;
	logic [T_W-1:0]   tstep_q;
	logic [TOL_W-1:0] tol_q;

	logic signed [31:0] ep_m_q, next_q, eps_q;
	logic [57:0]  k_q;
	logic [63:0]  prod_q;
	logic         d_neg_q, sneg_q;
	logic [63:0]  div_rem_q, div_quo_q, div_den_q;
	logic [119:0] acc_q;
	logic [34:0]  inc_q;
	logic [30:0]  sig_mag_q;
	logic         sig_neg_q;
	logic [31:0]  p_hi_q;
	logic [19:0]  vlo_q;
	logic [52:0]  den_q;
	logic [27:0]  tangent_q;
	logic signed [31:0] stress_q, nps_q;

	// combinational datapath
	logic [S0_W-1:0]    s0;
	logic signed [32:0] d;
	logic [32:0]        d_abs;
	logic [30:0]        smag;
	logic               yielding;
	logic [31:0]        mul_a, mul_b;
	logic [64:0]        rem_sh;
	logic               div_ge;
	logic [64:0]        rem_diff;
	logic signed [36:0] ep_ext, inc_ext, flow_sum;
	logic signed [31:0] flow_val;
	logic signed [32:0] delta;
	logic [32:0]        delta_abs;
	logic               conv;
	logic               div_run;
	logic [119:0]       pp_term;
	logic [51:0]        visc;
	logic [31:0]        h_est;

	assign s0       = (yield_q == '0) ? S0_W'(1) : yield_q;
	assign d        = {eps_q[31], eps_q} - {next_q[31], next_q};
	assign d_abs    = d[32] ? 33'(-d) : 33'(d);
	assign smag     = prod_q[52:22];
	assign yielding = smag > s0;
	assign h_est    = 32'(prod_q >> RECIP_SH);

	assign rem_sh   = {div_rem_q, div_quo_q[63]};
	assign rem_diff = rem_sh - {1'b0, div_den_q};
	assign div_ge   = !rem_diff[64];
	assign div_run  = (div_cnt_q != '0);

	assign ep_ext   = {{5{ep_m_q[31]}}, ep_m_q};
	assign inc_ext  = {2'b00, inc_q};
	assign flow_sum = sneg_q ? ep_ext - inc_ext : ep_ext + inc_ext;

	always_comb begin
		if (flow_sum[36:31] == '0 || flow_sum[36:31] == '1) begin
			flow_val = flow_sum[31:0];
		end else if (flow_sum[36]) begin
			flow_val = 32'sh8000_0000;
		end else begin
			flow_val = 32'sh7fff_ffff;
		end
	end

	assign delta     = {flow_val[31], flow_val} - {next_q[31], next_q};
	assign delta_abs = delta[32] ? 33'(-delta) : 33'(delta);
	assign conv      = (delta_abs < {3'b000, tol_q}) || (iter_cnt_q == ITER_W'(MAX_ITER - 1));

	assign visc = prod_q[51:0] + {32'd0, vlo_q};

	always_comb begin
		unique case (pp_idx_q)
			3'd1:    pp_term = {56'd0, prod_q};
			3'd2:    pp_term = {24'd0, prod_q, 32'd0};
			3'd3:    pp_term = {24'd0, prod_q, 32'd0};
			3'd4:    pp_term = {prod_q[55:0], 64'd0};
			default: pp_term = '0;
		endcase
	end

	// operand selection of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_HMUL: begin
				mul_a = tstep_q;
				mul_b = SUB_RECIP;
			end
			ST_HFIX: begin
				mul_a = h_est;
				mul_b = 32'(SUBSTEPS);
			end
			ST_KMUL: begin
				mul_a = div_quo_q[31:0];
				mul_b = eta_q;
			end
			ST_SMUL: begin
				mul_a = d_abs[31:0];
				mul_b = {12'd0, youngs_q};
			end
			ST_PP: begin
				unique case (pp_idx_q)
					3'd0:    begin mul_a = k_q[31:0];           mul_b = div_quo_q[31:0]; end
					3'd1:    begin mul_a = k_q[31:0];           mul_b = {3'd0, div_quo_q[60:32]}; end
					3'd2:    begin mul_a = {6'd0, k_q[57:32]};  mul_b = div_quo_q[31:0]; end
					3'd3:    begin mul_a = {6'd0, k_q[57:32]};  mul_b = {3'd0, div_quo_q[60:32]}; end
					default: begin mul_a = '0;                  mul_b = '0; end
				endcase
			end
			ST_TMUL0: begin
				mul_a = eta_q;
				mul_b = tstep_q;
			end
			ST_TMUL1: begin
				mul_a = prod_q[31:0];
				mul_b = {12'd0, youngs_q};
			end
			ST_TMUL2: begin
				mul_a = p_hi_q;
				mul_b = {12'd0, youngs_q};
			end
			ST_TMUL3: begin
				mul_a = {12'd0, youngs_q};
				mul_b = {1'b0, s0};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			youngs_q <= YOUNGS_RST;
			yield_q  <= YIELD_RST;
			eta_q    <= VISCOSITY_RST;
			tstep_q  <= TIME_STEP_RST;
			tol_q    <= TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_YOUNGS:    youngs_q <= cfg_data[E_W-1:0];
				REG_YIELD:     yield_q  <= cfg_data[S0_W-1:0];
				REG_VISCOSITY: eta_q    <= cfg_data[ETA_W-1:0];
				REG_TIME_STEP: tstep_q  <= cfg_data[T_W-1:0];
				REG_TOLERANCE: tol_q    <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_GUESS;
			sub_cnt_q  <= '0;
			iter_cnt_q <= '0;
			div_cnt_q  <= '0;
			pp_idx_q   <= '0;
			done_q     <= 1'b0;
			out_q      <= 1'b0;
		end else begin
			done_q <= out_q;
			out_q  <= 1'b0;
			if (div_run) begin
				div_cnt_q <= div_cnt_q - 7'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_HMUL;
						phase_q   <= PH_GUESS;
						sub_cnt_q <= '0;
					end
				end
				ST_HMUL: state_q <= ST_HFIX;
				ST_HFIX: state_q <= ST_HCOR;
				ST_HCOR: state_q <= ST_KMUL;
				ST_KMUL: state_q <= ST_KSET;
				ST_KSET: state_q <= ST_SMUL;
				ST_SMUL: state_q <= ST_STRESS;
				ST_STRESS: begin
					if (phase_q == PH_FINAL) begin
						if (sub_cnt_q == SUB_W'(SUBSTEPS - 1)) begin
							phase_q <= PH_DONE;
							state_q <= ST_TMUL0;
						end else begin
							sub_cnt_q <= sub_cnt_q + 1'b1;
							phase_q   <= PH_GUESS;
							state_q   <= ST_SMUL;
						end
					end else if (yielding) begin
						div_cnt_q <= 7'd61;
						state_q   <= ST_RDIV;
					end else begin
						state_q <= ST_APPLY;
					end
				end
				ST_RDIV: begin
					if (!div_run) begin
						pp_idx_q <= '0;
						state_q  <= ST_PP;
					end
				end
				ST_PP: begin
					pp_idx_q <= pp_idx_q + 3'd1;
					if (pp_idx_q == 3'd4) state_q <= ST_CAP;
				end
				ST_CAP: state_q <= ST_APPLY;
				ST_APPLY: begin
					state_q <= ST_SMUL;
					if (phase_q == PH_GUESS) begin
						phase_q    <= PH_ITER;
						iter_cnt_q <= '0;
					end else if (conv) begin
						phase_q <= PH_FINAL;
					end else begin
						iter_cnt_q <= iter_cnt_q + 1'b1;
					end
				end
				ST_TMUL0: begin
					if (sig_mag_q > s0) begin
						state_q <= ST_TMUL1;
					end else begin
						state_q <= ST_IDLE;
						out_q   <= 1'b1;
					end
				end
				ST_TMUL1: state_q <= ST_TMUL2;
				ST_TMUL2: state_q <= ST_TMUL3;
				ST_TMUL3: state_q <= ST_TMUL4;
				ST_TMUL4: begin
					div_cnt_q <= 7'd51;
					state_q   <= ST_TDIV;
				end
				ST_TDIV: begin
					if (!div_run) begin
						state_q <= ST_IDLE;
						out_q   <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
		if (div_run) begin
			div_rem_q <= div_ge ? rem_diff[63:0] : rem_sh[63:0];
			div_quo_q <= {div_quo_q[62:0], div_ge};
		end
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ep_m_q <= old_plastic_strain;
					next_q <= old_plastic_strain;
					eps_q  <= total_strain;
				end
			end
			ST_HFIX: div_quo_q <= {32'd0, h_est};
			// estimate may be one low, the remainder tells
			ST_HCOR: begin
				if ((tstep_q - prod_q[31:0]) >= 32'(SUBSTEPS)) div_quo_q <= div_quo_q + 64'd1;
			end
			ST_KSET: k_q <= prod_q[57:0];
			ST_SMUL: d_neg_q <= d[32];
			ST_STRESS: begin
				sneg_q <= d_neg_q;
				inc_q  <= '0;
				if (phase_q == PH_FINAL) begin
					sig_mag_q <= smag;
					sig_neg_q <= d_neg_q;
					ep_m_q    <= next_q;
				end else if (yielding) begin
					div_rem_q <= '0;
					div_quo_q <= {smag - s0, 33'd0};
					div_den_q <= {33'd0, s0};
				end
			end
			ST_PP: acc_q <= (pp_idx_q == 3'd0) ? '0 : acc_q + pp_term;
			ST_CAP: inc_q <= (acc_q[119:40] > {45'd0, INC_CAP}) ? INC_CAP : acc_q[74:40];
			ST_APPLY: next_q <= flow_val;
			ST_TMUL0: begin
				tangent_q <= {youngs_q, 8'd0};
				stress_q  <= sig_neg_q ? -$signed({1'b0, sig_mag_q}) : $signed({1'b0, sig_mag_q});
				nps_q     <= next_q;
			end
			ST_TMUL1: p_hi_q <= prod_q[63:32];
			ST_TMUL2: vlo_q <= prod_q[51:32];
			ST_TMUL3: den_q <= {22'd0, s0} + {1'b0, visc};
			ST_TMUL4: begin
				div_rem_q <= '0;
				div_quo_q <= {prod_q[50:0], 13'd0};
				div_den_q <= {11'd0, den_q};
			end
			ST_TDIV: if (!div_run) tangent_q <= div_quo_q[27:0];
			default: ;
		endcase
	end

	assign busy               = (state_q != ST_IDLE);
	assign done               = done_q;
	assign stress             = stress_q;
	assign new_plastic_strain = nps_q;
	assign tangent_modulus    = tangent_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_IDLE))
		else $error("result strobe without a finished transaction");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction accepted but sequencer stayed idle");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_run |-> (state_q == ST_RDIV || state_q == ST_TDIV))
		else $error("divider running outside a divide state");
	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_cnt_q <= SUB_W'(SUBSTEPS - 1))
		else $error("sub-step counter out of range");

endmodule

>>> tb/tb_top.sv
// self-checking testbench of the viscoplastic stress update: queued stimulus, predictor, monitor
module tb_top;
	import vsu_pkg::*;

	localparam int QUIET_LIMIT = 30000000;
	localparam int END_WAIT    = 200;

	typedef enum logic [1:0] {
		OP_ITEM,
		OP_CFG,
		OP_DRAIN
	} op_kind_t;

	typedef struct {
		op_kind_t          kind;
		reg_index_t        idx;
		logic [31:0]       data;
		logic signed [31:0] ep;
		logic signed [31:0] eps;
	} pending_op_t;

	typedef struct packed {
		logic signed [31:0] stress;
		logic signed [31:0] plastic;
		logic [27:0]        tangent;
	} point_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               done;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic signed [31:0] old_plastic_strain;
	logic signed [31:0] total_strain;
	logic signed [31:0] stress;
	logic signed [31:0] new_plastic_strain;
	logic [27:0]        tangent_modulus;

	pending_op_t   pending_ops[$];
	point_result_t expected_points[$];

	// predictor copy of the registers
	logic [63:0] mdl_e, mdl_s0, mdl_eta, mdl_t, mdl_tol;

	int gap_cnt;
	int mismatch_cnt = 0;
	int quiet_cnt;

	viscoplastic_stress_update u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.old_plastic_strain(old_plastic_strain),
		.total_strain(total_strain),
		.stress(stress),
		.new_plastic_strain(new_plastic_strain),
		.tangent_modulus(tangent_modulus)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint stress_at(longint eps, longint ep);
		longint d;
		logic [63:0] mag, q;
		d = eps - ep;
		mag = (d < 0) ? -d : d;
		q = (mag * mdl_e) >> 22;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint flow_step(longint ep_m, longint s, logic [63:0] k,
					     logic [63:0] s0);
		logic [63:0]  mag, r, inc;
		logic [127:0] prod;
		mag = (s < 0) ? -s : s;
		if (mag <= s0) return ep_m;
		r = ((mag - s0) << 30) / s0;
		prod = ({64'd0, k} * {64'd0, r}) >> 40;
		inc = (prod > {93'd0, INC_CAP}) ? {29'd0, INC_CAP} : prod[63:0];
		return sat32((s < 0) ? ep_m - longint'(inc) : ep_m + longint'(inc));
	endfunction

	function automatic point_result_t predict_point(logic signed [31:0] ep_in,
							logic signed [31:0] eps_in);
		point_result_t res;
		longint        ep_m, eps, sig, nxt, prv, diff;
		logic [63:0]   s0, k, absd, smag, visc, tg;
		logic [127:0]  visc_w;
		ep_m = longint'(ep_in);
		eps = longint'(eps_in);
		s0 = (mdl_s0 == 0) ? 64'd1 : mdl_s0;
		k = (mdl_t / SUBSTEPS) * mdl_eta;
		sig = 0;
		nxt = ep_m;
		for (int i = 0; i < SUBSTEPS; i++) begin
			// forward-euler guess, then fixed-point iterations
			nxt = flow_step(ep_m, stress_at(eps, ep_m), k, s0);
			for (int j = 0; j < MAX_ITER; j++) begin
				prv = nxt;
				nxt = flow_step(ep_m, stress_at(eps, nxt), k, s0);
				diff = nxt - prv;
				absd = (diff < 0) ? -diff : diff;
				if (absd < mdl_tol) break;
			end
			sig = stress_at(eps, nxt);
			ep_m = nxt;
		end
		smag = (sig < 0) ? -sig : sig;
		if (smag > s0) begin
			visc_w = ({64'd0, mdl_eta * mdl_t} * {64'd0, mdl_e}) >> 32;
			visc = (visc_w > (128'd1 << 60)) ? (64'd1 << 60) : visc_w[63:0];
			tg = (mdl_e * s0) / (s0 + visc);
		end else begin
			tg = mdl_e << 8;
		end
		res.stress = 32'(sat32(sig));
		res.plastic = 32'(sat32(nxt));
		res.tangent = tg[27:0];
		return res;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
		return $urandom_range(10, 60);
	endfunction

	// driver: one transaction per free slot, config only when the block is idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			old_plastic_strain <= '0;
			total_strain <= '0;
			gap_cnt <= 0;
			mdl_e <= 64'(YOUNGS_RST);
			mdl_s0 <= 64'(YIELD_RST);
			mdl_eta <= 64'(VISCOSITY_RST);
			mdl_t <= 64'(TIME_STEP_RST);
			mdl_tol <= 64'(TOLERANCE_RST);
		end else begin
			cfg_we <= 1'b0;
			if (start && !busy)
				expected_points.push_back(predict_point(old_plastic_strain, total_strain));
			if (!start || !busy) begin
				if (gap_cnt > 0) begin
					gap_cnt <= gap_cnt - 1;
					start <= 1'b0;
				end else if (pending_ops.size() == 0) begin
					start <= 1'b0;
				end else if (pending_ops[0].kind == OP_ITEM) begin
					start <= 1'b1;
					old_plastic_strain <= pending_ops[0].ep;
					total_strain <= pending_ops[0].eps;
					void'(pending_ops.pop_front());
					gap_cnt <= pick_gap();
				end else begin
					start <= 1'b0;
					if (expected_points.size() == 0 && !busy && !start) begin
						if (pending_ops[0].kind == OP_CFG) begin
							cfg_we <= 1'b1;
							cfg_index <= pending_ops[0].idx;
							cfg_data <= pending_ops[0].data;
							case (pending_ops[0].idx)
								REG_YOUNGS:    mdl_e <= 64'(pending_ops[0].data & 32'hFFFFF);
								REG_YIELD:     mdl_s0 <= 64'(pending_ops[0].data & 32'h7FFFFFFF);
								REG_VISCOSITY: mdl_eta <= 64'(pending_ops[0].data);
								REG_TIME_STEP: mdl_t <= 64'(pending_ops[0].data);
								REG_TOLERANCE: mdl_tol <= 64'(pending_ops[0].data & 32'h3FFFFFFF);
								default: ;
							endcase
						end
						void'(pending_ops.pop_front());
					end
				end
			end
		end
	end

	// monitor: results cannot be held off, compare each against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_points.size() == 0) begin
				mismatch_cnt <= mismatch_cnt + 1;
				if (mismatch_cnt < 10)
					$display("unexpected result: stress %0d plastic %0d tangent %0d",
						 stress, new_plastic_strain, tangent_modulus);
			end else begin
				if (expected_points[0].stress !== stress ||
				    expected_points[0].plastic !== new_plastic_strain ||
				    expected_points[0].tangent !== tangent_modulus) begin
					mismatch_cnt <= mismatch_cnt + 1;
					if (mismatch_cnt < 10)
						$display("result mismatch: stress %0d/%0d plastic %0d/%0d tangent %0d/%0d",
							 expected_points[0].stress, stress,
							 expected_points[0].plastic, new_plastic_strain,
							 expected_points[0].tangent, tangent_modulus);
				end
				void'(expected_points.pop_front());
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			quiet_cnt <= 0;
		end else if (quiet_cnt >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
		end
	end

	task automatic add_item(logic signed [31:0] ep, logic signed [31:0] eps);
		pending_op_t op;
		op.kind = OP_ITEM;
		op.idx = REG_YOUNGS;
		op.data = '0;
		op.ep = ep;
		op.eps = eps;
		pending_ops.push_back(op);
	endtask

	task automatic add_cfg(reg_index_t idx, logic [31:0] data);
		pending_op_t op;
		op.kind = OP_CFG;
		op.idx = idx;
		op.data = data;
		op.ep = '0;
		op.eps = '0;
		pending_ops.push_back(op);
	endtask

	task automatic add_drain();
		pending_op_t op;
		op.kind = OP_DRAIN;
		op.idx = REG_YOUNGS;
		op.data = '0;
		op.ep = '0;
		op.eps = '0;
		pending_ops.push_back(op);
	endtask

	task automatic add_config(logic [31:0] e, logic [31:0] s0, logic [31:0] eta,
				  logic [31:0] t, logic [31:0] tol);
		add_cfg(REG_YOUNGS, e);
		add_cfg(REG_YIELD, s0);
		add_cfg(REG_VISCOSITY, eta);
		add_cfg(REG_TIME_STEP, t);
		add_cfg(REG_TOLERANCE, tol);
	endtask

	// strain pair around a moderate plastic strain, offset within +-span
	task automatic add_near(int unsigned span);
		logic signed [31:0] ep;
		ep = $signed($urandom) >>> 1;
		add_item(ep, ep + $signed($urandom_range(0, 2 * span)) - $signed(span));
	endtask

	initial begin
		logic signed [31:0] ep;
		arst_n = 1'b0;

		// reset settings, elastic range only
		add_item(32'sd0, 32'sd0);
		add_item(32'h80000000, 32'h80000000);
		add_item(32'h7FFFFFFF, 32'h7FFFFFFF);
		add_item(32'sd0, 32'sd1000000);
		add_item(32'sd5, -32'sd1000000);
		for (int n = 0; n < 110; n++)
			add_near(1000000);

		// no viscous flow, full-range strains, maximum modulus with masked upper bits
		add_config(32'hABCFFFFF, 32'(YIELD_RST), 32'd0, TIME_STEP_RST, 32'd1);
		add_item(32'h80000000, 32'h7FFFFFFF);
		add_item(32'h7FFFFFFF, 32'h80000000);
		add_item(32'h80000000, 32'h80000000);
		for (int n = 0; n < 80; n++) begin
			add_item($urandom, $urandom);
			if (n == 40)
				add_drain();
		end

		// sub-step shorter than one unit, zero yield stress, modulus of one
		add_config(32'd1, 32'd0, 32'hFFFFFFFF, 32'd50, 32'd1);
		for (int n = 0; n < 30; n++)
			add_item($urandom, $urandom);

		// zero modulus
		add_cfg(REG_YOUNGS, 32'd0);
		for (int n = 0; n < 15; n++)
			add_item($urandom, $urandom);

		// converging plastic flow
		add_config(32'd100000, 32'd25600, 32'd256, 32'd16777216, 32'd10737);
		add_item(32'sd0, 32'sd268435456);
		add_item(32'sd0, -32'sd268435456);
		add_item(32'h7FFFFFFF, 32'h80000000);
		add_item(32'h80000000, 32'h7FFFFFFF);
		add_item(32'sd0, 32'sd536870912);
		for (int n = 0; n < 40; n++) begin
			ep = $signed($urandom_range(0, 32'h02000000)) - 32'sd16777216;
			add_item(ep, ep + $signed($urandom_range(0, 32'h04000000)) - 32'sd33554432);
		end

		// widest tolerance
		add_cfg(REG_TOLERANCE, 32'h3FFFFFFF);
		for (int n = 0; n < 10; n++)
			add_near(33554432);

		// all registers at the top, zero tolerance: every iteration runs
		add_config(32'hFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
		add_item($urandom, $urandom);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || expected_points.size() != 0 || start || busy)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
